[rtl/core/sfc_pkg.sv]
`default_nettype none

package sfc_pkg;

  // Packet limits and byte counter sizing.
  localparam int unsigned MAX_PACKET_BYTES = 255;
  localparam int unsigned COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(256);
  localparam int unsigned NUM_WORDS = 4;

  // Fixed packet constants.
  localparam logic [15:0] HDR_WORD = 16'hA57E;
  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;

  // Register reset values.
  localparam logic [15:0] OWN_ADDR_RESET = 16'h0010;
  localparam logic [7:0] TYPE_RESET = 8'h01;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_ACCEPTED_TYPE = CFG_INDEX_W'(1);

  // Byte positions within a packet.
  localparam logic [COUNT_W-1:0] POS_HDR_HI = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] POS_HDR_LO = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] POS_LENGTH = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS_ADDR_LO = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] POS_ADDR_HI = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] POS_ID_LO = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] POS_ID_HI = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] POS_TYPE = COUNT_W'(7);
  localparam logic [COUNT_W-1:0] POS_TEMP_LO = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] POS_TEMP_HI = COUNT_W'(9);
  localparam logic [COUNT_W-1:0] POS_BATT_LO = COUNT_W'(10);
  localparam logic [COUNT_W-1:0] POS_BATT_HI = COUNT_W'(11);
  localparam logic [COUNT_W-1:0] POS_ADC_LO = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] POS_ADC_HI = COUNT_W'(13);

  // Payload word slots.
  localparam int unsigned WORD_ID = 0;
  localparam int unsigned WORD_TEMP = 1;
  localparam int unsigned WORD_BATT = 2;
  localparam int unsigned WORD_ADC = 3;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_LENGTH   = 3'd1,
    STATUS_HEADER   = 3'd2,
    STATUS_CHECKSUM = 3'd3,
    STATUS_ADDRESS  = 3'd4,
    STATUS_TYPE     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [15:0]        sensor_id;
    logic signed [15:0] temperature;
    logic [15:0]        battery;
    logic [15:0]        adc_value;
  } out_item_t;

  // Packet fields with the current byte overlaid; sum covers only the earlier bytes.
  typedef struct packed {
    logic [COUNT_W-1:0]          count;
    logic [7:0]                  sum;
    logic [7:0]                  length;
    logic [15:0]                 header;
    logic [15:0]                 address;
    logic [7:0]                  pkt_type;
    logic [NUM_WORDS-1:0][15:0]  words;
  } pkt_view_t;

endpackage

`default_nettype wire

[rtl/core/sensor_frame_checker.sv]
`default_nettype none

// Result: the result of a packet is presented in the cycle after its final byte is accepted.
// Throughput: one byte per cycle; the final byte of a packet waits only while a previous
// result is still held by a stalled output register.
// Reset: packet state clears, own_address returns to 0x0010 and accepted_type to 0x01,
// and the output register empties.
module sensor_frame_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire sfc_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output sfc_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [15:0]                        cfg_data
);
  import sfc_pkg::*;

  logic [15:0] own_address;
  logic [7:0]  accepted_type;
  logic        in_take;
  logic        out_free;
  pkt_view_t   view;
  status_t     status_next;
  out_item_t   result_next;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDR_RESET;
      accepted_type <= TYPE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_ADDRESS:   own_address <= cfg_data;
        CFG_ACCEPTED_TYPE: accepted_type <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Middle bytes never need the output slot; only a final byte waits on it.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = in_data.last_byte && !out_free;
  assign in_take = in_valid && !in_stall;

  sfc_capture u_capture (
    .clk  (clk),
    .rst  (rst),
    .take (in_take),
    .item (in_data),
    .view (view)
  );

  // Checks in priority order on the fields including the final byte.
  always_comb begin
    if ((view.count > COUNT_W'(MAX_PACKET_BYTES)) || ({1'b0, view.length} != view.count)) begin
      status_next = STATUS_LENGTH;
    end else if (view.header != HDR_WORD) begin
      status_next = STATUS_HEADER;
    end else if (in_data.data_byte != view.sum) begin
      status_next = STATUS_CHECKSUM;
    end else if ((view.address != own_address) && (view.address != BROADCAST_ADDR)) begin
      status_next = STATUS_ADDRESS;
    end else if (view.pkt_type != accepted_type) begin
      status_next = STATUS_TYPE;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // Decoded fields are passed only for a packet that passed every check.
  always_comb begin
    result_next = '0;
    result_next.status = status_next;
    if (status_next == STATUS_OK) begin
      result_next.sensor_id = view.words[WORD_ID];
      result_next.temperature = signed'(view.words[WORD_TEMP]);
      result_next.battery = view.words[WORD_BATT];
      result_next.adc_value = view.words[WORD_ADC];
    end
  end

  // Output register: loads on a final byte, empties when the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_data.last_byte) begin
      out_data <= result_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sfc_capture.sv]
`default_nettype none

module sfc_capture (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire sfc_pkg::in_item_t item,
  output sfc_pkg::pkt_view_t     view
);
  import sfc_pkg::*;

  logic [COUNT_W-1:0]         byte_count;
  logic [7:0]                 running_sum;
  logic [7:0]                 length_field;
  logic [15:0]                header_bytes;
  logic [15:0]                dest_address;
  logic [7:0]                 type_field;
  logic [NUM_WORDS-1:0][15:0] payload_words;

  // Overlay the incoming byte on the captured fields at its position.
  always_comb begin
    view.count = (byte_count == COUNT_SAT) ? byte_count : byte_count + COUNT_W'(1);
    view.sum = running_sum;
    view.length = length_field;
    view.header = header_bytes;
    view.address = dest_address;
    view.pkt_type = type_field;
    view.words = payload_words;
    case (byte_count)
      POS_HDR_HI:  view.header[15:8] = item.data_byte;
      POS_HDR_LO:  view.header[7:0] = item.data_byte;
      POS_LENGTH:  view.length = item.data_byte;
      POS_ADDR_LO: view.address[7:0] = item.data_byte;
      POS_ADDR_HI: view.address[15:8] = item.data_byte;
      POS_ID_LO:   view.words[WORD_ID][7:0] = item.data_byte;
      POS_ID_HI:   view.words[WORD_ID][15:8] = item.data_byte;
      POS_TYPE:    view.pkt_type = item.data_byte;
      POS_TEMP_LO: view.words[WORD_TEMP][7:0] = item.data_byte;
      POS_TEMP_HI: view.words[WORD_TEMP][15:8] = item.data_byte;
      POS_BATT_LO: view.words[WORD_BATT][7:0] = item.data_byte;
      POS_BATT_HI: view.words[WORD_BATT][15:8] = item.data_byte;
      POS_ADC_LO:  view.words[WORD_ADC][7:0] = item.data_byte;
      POS_ADC_HI:  view.words[WORD_ADC][15:8] = item.data_byte;
      default: ;
    endcase
  end

  // Packet state: updated on every byte, cleared after the final one.
  always_ff @(posedge clk) begin
    if (rst || (take && item.last_byte)) begin
      byte_count <= '0;
      running_sum <= '0;
      length_field <= '0;
      header_bytes <= '0;
      dest_address <= '0;
      type_field <= '0;
      payload_words <= '0;
    end else if (take) begin
      byte_count <= view.count;
      running_sum <= running_sum + item.data_byte;
      length_field <= view.length;
      header_bytes <= view.header;
      dest_address <= view.address;
      type_field <= view.pkt_type;
      payload_words <= view.words;
    end
  end

endmodule

`default_nettype wire
